### src/sbsc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sixteen-lane byte-sum checksum.
// This package has no dependencies. Every module in src imports it.
package sbsc_pkg;

    localparam int LANES      = 16;
    localparam int HALF_LANES = LANES / 2;
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int CFG_IDX_W  = 2;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = 1;
    localparam int Q_CNT_W    = 2;

    localparam logic [BYTE_W-1:0] LANE_INV = 8'hFF;

    typedef logic [LANES-1:0][BYTE_W-1:0] lanes_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEED_LOW  = 2'd0,
        REG_SEED_HIGH = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        lanes_t              lanes;
        logic [WORD_W-1:0]   exp_high;
        logic [WORD_W-1:0]   exp_low;
    } region_t;

    typedef struct packed {
        logic valid;
    } q_hs_t;

endpackage

### src/sbsc_front.sv
`timescale 1ns / 1ps
// Front end: accepts data words and accumulates the sixteen lane sums.
// Hands the raw sums of each finished region to the queue. Uses sbsc_pkg.
module sbsc_front
    import sbsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [WORD_W-1:0]   seed_low,
    input  logic [WORD_W-1:0]   seed_high,
    input  logic                accept,
    input  logic [WORD_W-1:0]   data_word,
    input  logic                last,
    input  logic [WORD_W-1:0]   expected_low,
    input  logic [WORD_W-1:0]   expected_high,
    output logic                q_push,
    output region_t             q_data
);

    lanes_t lanes_reg;
    lanes_t lanes_next;
    lanes_t base_lanes;
    logic   region_open_reg;
    logic   region_open_next;
    logic   upper_half_reg;
    logic   upper_half_next;
    logic   upper;

    assign base_lanes = region_open_reg ? lanes_reg : lanes_t'({seed_high, seed_low});
    assign upper      = region_open_reg & upper_half_reg;

    always_comb
    begin
        lanes_next = base_lanes;
        for (int i = 0; i < HALF_LANES; i++)
        begin
            if (upper)
            begin
                lanes_next[i + HALF_LANES] = base_lanes[i + HALF_LANES]
                                             + data_word[i*BYTE_W +: BYTE_W];
            end
            else
            begin
                lanes_next[i] = base_lanes[i] + data_word[i*BYTE_W +: BYTE_W];
            end
        end
    end

    always_comb
    begin
        region_open_next = region_open_reg;
        upper_half_next  = upper_half_reg;
        if (accept)
        begin
            region_open_next = ~last;
            upper_half_next  = ~upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_open_reg <= 1'b0;
            upper_half_reg  <= 1'b0;
        end
        else
        begin
            region_open_reg <= region_open_next;
            upper_half_reg  <= upper_half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lanes_reg <= lanes_next;
        end
    end

    assign q_push          = accept & last;
    assign q_data.lanes    = lanes_next;
    assign q_data.exp_low  = expected_low;
    assign q_data.exp_high = expected_high;

endmodule

### src/sbsc_queue.sv
`timescale 1ns / 1ps
// Two-entry queue of finished regions between front and back end.
// Uses region_t and queue sizing from sbsc_pkg.
module sbsc_queue
    import sbsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  region_t  push_data,
    output logic     full,
    output q_hs_t    hs_out_valid,
    input  logic     pop_ready,
    output region_t  pop_data
);

    region_t              mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign do_push  = push & ~full;
    assign do_pop   = pop_ready & (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    assign hs_out_valid.valid = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### src/sbsc_back.sv
`timescale 1ns / 1ps
// Back end: two-stage lane fix-up, checksum compare and result register.
// Uses lanes_t, region_t and LANE_INV from sbsc_pkg.
module sbsc_back
    import sbsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  q_hs_t               hs_in,
    output logic                in_ready,
    input  region_t             in_data,
    input  logic                pop,
    output logic                empty,
    output logic [WORD_W-1:0]   sum_low,
    output logic [WORD_W-1:0]   sum_high,
    output logic                mismatch
);

    logic                a_valid_reg;
    logic                a_valid_next;
    lanes_t              a_lanes_reg;
    logic [WORD_W-1:0]   a_exp_low_reg;
    logic [WORD_W-1:0]   a_exp_high_reg;
    logic                b_valid_reg;
    logic                b_valid_next;
    lanes_t              b_lanes_reg;
    logic                b_mismatch_reg;
    logic                a_ready;
    logic                b_ready;
    logic                a_load;
    logic                b_load;
    lanes_t              fix_a;
    lanes_t              fix_b;

    assign b_ready  = ~b_valid_reg | pop;
    assign a_ready  = ~a_valid_reg | b_ready;
    assign in_ready = a_ready;
    assign a_load   = hs_in.valid & a_ready;
    assign b_load   = a_valid_reg & b_ready;

    always_comb
    begin
        fix_a = in_data.lanes;
        for (int i = 1; i < HALF_LANES; i++)
        begin
            if (fix_a[i] == fix_a[i-1])
            begin
                fix_a[i] = fix_a[i] ^ LANE_INV;
            end
        end
    end

    always_comb
    begin
        fix_b = a_lanes_reg;
        for (int i = HALF_LANES; i < LANES - 1; i++)
        begin
            if (fix_b[i] == fix_b[i-1])
            begin
                fix_b[i] = fix_b[i] ^ LANE_INV;
            end
        end
    end

    always_comb
    begin
        a_valid_next = a_load | (a_valid_reg & ~b_ready);
        b_valid_next = b_load | (b_valid_reg & ~pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_lanes_reg    <= fix_a;
            a_exp_low_reg  <= in_data.exp_low;
            a_exp_high_reg <= in_data.exp_high;
        end
        if (b_load)
        begin
            b_lanes_reg    <= fix_b;
            b_mismatch_reg <= (fix_b != lanes_t'({a_exp_high_reg, a_exp_low_reg}));
        end
    end

    assign empty    = ~b_valid_reg;
    assign sum_low  = b_lanes_reg[HALF_LANES-1:0];
    assign sum_high = b_lanes_reg[LANES-1:HALF_LANES];
    assign mismatch = b_mismatch_reg;

endmodule

### src/sixteen_lane_byte_sum_checksum.sv
`timescale 1ns / 1ps
// Sixteen-lane byte-sum checksum, top level: seed registers, front end, queue, back end.
// Depends on sbsc_pkg, sbsc_front, sbsc_queue and sbsc_back.
// Throughput: one data word per cycle while full is low; full rises only when the two-entry queue fills.
// A region's result passes through the queue, fix-up stage A and result stage B before empty goes low.
// The queue and the two fix-up stages hold up to four results waiting to be popped.
// Reset clears seeds to zero, closes the open region and empties queue and pipeline.
module sixteen_lane_byte_sum_checksum
    import sbsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_IDX_W-1:0]   wr_index,
    input  logic [WORD_W-1:0]      wr_data,
    input  logic                   push,
    output logic                   full,
    input  logic [WORD_W-1:0]      data_word,
    input  logic                   last,
    input  logic [WORD_W-1:0]      expected_low,
    input  logic [WORD_W-1:0]      expected_high,
    output logic                   empty,
    input  logic                   pop,
    output logic [WORD_W-1:0]      sum_low,
    output logic [WORD_W-1:0]      sum_high,
    output logic                   mismatch
);

    logic [WORD_W-1:0]   seed_low_reg;
    logic [WORD_W-1:0]   seed_high_reg;
    logic                accept;
    logic                q_push;
    region_t             q_in;
    region_t             q_out;
    q_hs_t               q_hs;
    logic                back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_low_reg  <= '0;
            seed_high_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SEED_LOW:  seed_low_reg  <= wr_data;
                REG_SEED_HIGH: seed_high_reg <= wr_data;
                default:       ;
            endcase
        end
    end

    assign accept = push & ~full;

    sbsc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .seed_low      (seed_low_reg),
        .seed_high     (seed_high_reg),
        .accept        (accept),
        .data_word     (data_word),
        .last          (last),
        .expected_low  (expected_low),
        .expected_high (expected_high),
        .q_push        (q_push),
        .q_data        (q_in)
    );

    sbsc_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (q_push),
        .push_data    (q_in),
        .full         (full),
        .hs_out_valid (q_hs),
        .pop_ready    (back_ready),
        .pop_data     (q_out)
    );

    sbsc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .hs_in    (q_hs),
        .in_ready (back_ready),
        .in_data  (q_out),
        .pop      (pop),
        .empty    (empty),
        .sum_low  (sum_low),
        .sum_high (sum_high),
        .mismatch (mismatch)
    );

endmodule

### src/sbsc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the checksum block, bound to the top level.
// Counts regions closed against results popped. Uses sbsc_pkg.
module sbsc_checker
    import sbsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  logic                last,
    input  logic                empty,
    input  logic                pop,
    input  logic [WORD_W-1:0]   sum_low,
    input  logic [WORD_W-1:0]   sum_high,
    input  logic                mismatch
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       close_beat;
    logic       pop_beat;

    assign close_beat   = push & ~full & last;
    assign pop_beat     = pop & ~empty;
    assign pending_next = pending_reg + 3'(close_beat) - 3'(pop_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pending_reg != 3'd0)
        else $error("result shown with no closed region pending");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd4)
        else $error("more results pending than the block can hold");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(sum_low) && $stable(sum_high)
                              && $stable(mismatch)))
        else $error("stalled result beat changed");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (close_beat && pending_reg == 3'd0) |-> ##3 !empty)
        else $error("result of a closed region did not appear in time");

endmodule

bind sixteen_lane_byte_sum_checksum sbsc_checker u_sbsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .last     (last),
    .empty    (empty),
    .pop      (pop),
    .sum_low  (sum_low),
    .sum_high (sum_high),
    .mismatch (mismatch)
);
